@@ hdl/bmf3x3_pkg.sv @@
// Shared types, constants and helper functions for the 3x3 binary majority filter.
// Used by binary_majority_filter_3x3_top; depends on nothing else.
package bmf3x3_pkg;

  // Position counters and configured image dimensions.
  localparam int unsigned CNT_W = 12;
  localparam int unsigned DIM_W = 13;

  // Result queue between the filter stage and the output channel.
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned FIFO_CW    = 4;

  // Up to four results can follow from one input pixel.
  localparam int unsigned N_RES = 4;
  localparam int unsigned RES_W = 3;

  // Register reset values.
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  // Window neighborhoods. Bit 3*k+j holds column C-2+k of row R-2+j.
  localparam logic [8:0] REGION_ALL   = 9'b111111111;
  localparam logic [8:0] REGION_RIGHT = 9'b111111000;
  localparam logic [8:0] REGION_LOWER = 9'b110110110;
  localparam logic [8:0] REGION_CORNER = 9'b110110000;

  // Configuration register indexes.
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // One filtered pixel as it leaves the block.
  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             pix;
    logic             done;
  } result_t;

  // A pixel is set when the ones among the selected neighbors are more than half of them.
  function automatic logic majority(input logic [8:0] win, input logic [8:0] sel);
    logic [3:0] ones;
    logic [3:0] total;
    ones  = '0;
    total = '0;
    for (int i = 0; i < 9; i++) begin
      ones  = ones + 4'(win[i] & sel[i]);
      total = total + 4'(sel[i]);
    end
    return ({ones, 1'b0} > {1'b0, total});
  endfunction

endpackage

@@ hdl/binary_majority_filter_3x3_top.sv @@
// Top level of the streaming 3x3 binary majority filter.
// Depends on bmf3x3_pkg and bmf3x3_ram.
//
// Usage:
//   Pixels arrive on the in_ channel (valid/ready), one bit per beat, in raster order.
//   Each filtered pixel leaves on the out_ channel with its row and column; a pixel is 1
//   when the ones in its in-image 3x3 neighborhood are more than half of that neighborhood.
//   Image width and height are set over the APB port (register 0 at address 0, register 1
//   at address 4); a write restarts the frame at row 0, column 0.
//   The results of an input beat pass the filter stage registers and are written into the
//   result queue, from whose head they are offered on the out_ channel.
//   In raster terms output trails input by one row and one column; the last column and the
//   last row of a frame release the remaining pixels, up to four results for one input.
//   Throughput: one pixel per cycle while results drain at one per cycle. The result queue
//   (eight entries) sets the figure: input is taken while queued plus in-flight results
//   leave room for four more. In the last row two results per pixel make the output channel
//   the limit.
//   A stalled receiver fills the queue and then holds in_ready low; nothing is lost.
//   Reset clears counters, the window and the queue and loads width 640 and height 480.
//   Line buffer contents are not cleared: cells outside the image are never counted.
module binary_majority_filter_3x3_top #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Pixel input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_pixel_in,
  // Filtered pixel output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_row,
  output logic [11:0] out_col,
  output logic        out_pixel_out,
  output logic        out_frame_done,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MAX_LINE);
  localparam logic [bmf3x3_pkg::DIM_W-1:0] DIM_LIM =
    bmf3x3_pkg::DIM_W'((MAX_LINE < 4096) ? MAX_LINE : 4096);

  // Last valid index of a dimension after zero and range saturation.
  function automatic logic [bmf3x3_pkg::CNT_W-1:0] last_idx(
    input logic [bmf3x3_pkg::DIM_W-1:0] v
  );
    logic [bmf3x3_pkg::DIM_W-1:0] lim;
    lim = DIM_LIM - 13'd1;
    if (v == '0) begin
      return '0;
    end else if (v > DIM_LIM) begin
      return lim[bmf3x3_pkg::CNT_W-1:0];
    end
    return bmf3x3_pkg::CNT_W'(v - 13'd1);
  endfunction

  // Configuration registers.
  logic [bmf3x3_pkg::DIM_W-1:0] width_r;
  logic [bmf3x3_pkg::DIM_W-1:0] height_r;
  logic [bmf3x3_pkg::CNT_W-1:0] wlast_r;
  logic [bmf3x3_pkg::CNT_W-1:0] hlast_r;
  logic                         cfg_wr;
  bmf3x3_pkg::reg_idx_t         cfg_idx;

  // Position of the next input pixel.
  logic [bmf3x3_pkg::CNT_W-1:0] row_count_r;
  logic [bmf3x3_pkg::CNT_W-1:0] col_count_r;
  logic [bmf3x3_pkg::CNT_W-1:0] r_cur;
  logic [bmf3x3_pkg::CNT_W-1:0] c_cur;
  logic [bmf3x3_pkg::CNT_W-1:0] row_count_nxt;
  logic [bmf3x3_pkg::CNT_W-1:0] col_count_nxt;
  logic                         in_acc;

  // Filter stage registers.
  logic                         s1_v_r;
  logic                         s1_p_r;
  logic [bmf3x3_pkg::CNT_W-1:0] s1_row_r;
  logic [bmf3x3_pkg::CNT_W-1:0] s1_col_r;
  logic                         fwd_r;
  logic [1:0]                   fwd_word_r;
  logic [8:0]                   window_r;
  logic [8:0]                   window_nxt;

  // Line buffer port signals. Word bit 0 is the row two above, bit 1 the row above.
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [1:0]    ram_q;
  logic [1:0]    line_word;
  logic [1:0]    wr_word;

  // Results of the current filter stage beat.
  bmf3x3_pkg::result_t             res     [bmf3x3_pkg::N_RES];
  logic [bmf3x3_pkg::N_RES-1:0]    res_v;
  logic [bmf3x3_pkg::RES_W-1:0]    res_n;
  logic [bmf3x3_pkg::FIFO_AW-1:0]  wr_idx  [bmf3x3_pkg::N_RES];
  logic [2:0]                      row_ok;
  logic [2:0]                      col_ok;
  logic [8:0]                      in_img;
  logic                            row_ge1;
  logic                            col_ge1;
  logic                            row_last;
  logic                            col_last;

  // Result queue.
  bmf3x3_pkg::result_t              fifo_r [bmf3x3_pkg::FIFO_DEPTH];
  logic [bmf3x3_pkg::FIFO_AW-1:0]   wptr_r;
  logic [bmf3x3_pkg::FIFO_AW-1:0]   rptr_r;
  logic [bmf3x3_pkg::FIFO_CW-1:0]   cnt_r;
  logic [bmf3x3_pkg::FIFO_CW-1:0]   cnt_nxt;
  logic [bmf3x3_pkg::FIFO_CW-1:0]   pend;
  logic                             out_acc;

  // APB decode; pready is always high.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = bmf3x3_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      bmf3x3_pkg::REG_WIDTH:  prdata = {19'd0, width_r};
      bmf3x3_pkg::REG_HEIGHT: prdata = {19'd0, height_r};
      default:                prdata = '0;
    endcase
  end

  // Configuration registers with their saturated last indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bmf3x3_pkg::WIDTH_RST;
      height_r <= bmf3x3_pkg::HEIGHT_RST;
      wlast_r  <= last_idx(bmf3x3_pkg::WIDTH_RST);
      hlast_r  <= last_idx(bmf3x3_pkg::HEIGHT_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        bmf3x3_pkg::REG_WIDTH: begin
          width_r <= pwdata[12:0];
          wlast_r <= last_idx(pwdata[12:0]);
        end
        bmf3x3_pkg::REG_HEIGHT: begin
          height_r <= pwdata[12:0];
          hlast_r  <= last_idx(pwdata[12:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // Input side: position of the arriving pixel and the next position.
  assign in_acc = in_valid & in_ready;

  always_comb begin
    r_cur = (row_count_r > hlast_r) ? '0 : row_count_r;
    c_cur = (col_count_r > wlast_r) ? '0 : col_count_r;
    if (c_cur == wlast_r) begin
      col_count_nxt = '0;
      row_count_nxt = (r_cur == hlast_r) ? '0 : r_cur + 12'd1;
    end else begin
      col_count_nxt = c_cur + 12'd1;
      row_count_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
    end else if (cfg_wr) begin
      row_count_r <= '0;
      col_count_r <= '0;
    end else if (in_acc) begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  // Line buffer: read at the arriving column, write back from the filter stage registers.
  assign rd_addr = AW'(c_cur);
  assign wr_addr = AW'(s1_col_r);

  bmf3x3_ram #(
    .WIDTH (2),
    .DEPTH (MAX_LINE)
  ) u_line (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (wr_addr),
    .wdata (wr_word),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // A one-pixel-wide image reads the entry that is being written in the same cycle.
  assign line_word = fwd_r ? fwd_word_r : ram_q;
  assign wr_word   = {s1_p_r, line_word[1]};

  // Filter stage control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  // Filter stage payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_p_r     <= in_pixel_in;
      s1_row_r   <= r_cur;
      s1_col_r   <= c_cur;
      fwd_r      <= s1_v_r && (wr_addr == rd_addr);
      fwd_word_r <= wr_word;
    end
  end

  // Shift the new column into the 3x3 window.
  assign window_nxt = {s1_p_r, line_word[1], line_word[0], window_r[8:3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (cfg_wr) begin
      window_r <= '0;
    end else if (s1_v_r) begin
      window_r <= window_nxt;
    end
  end

  // Window cells that lie inside the image.
  assign row_ge1  = (s1_row_r != '0);
  assign col_ge1  = (s1_col_r != '0);
  assign row_last = (s1_row_r == hlast_r);
  assign col_last = (s1_col_r == wlast_r);
  assign row_ok   = {1'b1, row_ge1, (s1_row_r > 12'd1)};
  assign col_ok   = {1'b1, col_ge1, (s1_col_r > 12'd1)};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        in_img[3*k+j] = row_ok[j] & col_ok[k];
      end
    end
  end

  // The up to four results of this pixel, in emission order.
  always_comb begin
    res_v[0] = s1_v_r & row_ge1 & col_ge1;
    res_v[1] = s1_v_r & row_ge1 & col_last;
    res_v[2] = s1_v_r & row_last & col_ge1;
    res_v[3] = s1_v_r & row_last & col_last;

    res[0].row  = s1_row_r - 12'd1;
    res[0].col  = s1_col_r - 12'd1;
    res[0].pix  = bmf3x3_pkg::majority(window_nxt, in_img & bmf3x3_pkg::REGION_ALL);
    res[0].done = 1'b0;

    res[1].row  = s1_row_r - 12'd1;
    res[1].col  = s1_col_r;
    res[1].pix  = bmf3x3_pkg::majority(window_nxt, in_img & bmf3x3_pkg::REGION_RIGHT);
    res[1].done = 1'b0;

    res[2].row  = s1_row_r;
    res[2].col  = s1_col_r - 12'd1;
    res[2].pix  = bmf3x3_pkg::majority(window_nxt, in_img & bmf3x3_pkg::REGION_LOWER);
    res[2].done = 1'b0;

    res[3].row  = s1_row_r;
    res[3].col  = s1_col_r;
    res[3].pix  = bmf3x3_pkg::majority(window_nxt, in_img & bmf3x3_pkg::REGION_CORNER);
    res[3].done = 1'b1;
  end

  // Pack the valid results into consecutive queue slots.
  always_comb begin
    res_n = '0;
    for (int i = 0; i < bmf3x3_pkg::N_RES; i++) begin
      wr_idx[i]  = wptr_r + bmf3x3_pkg::FIFO_AW'(res_n[1:0]);
      res_n      = res_n + bmf3x3_pkg::RES_W'(res_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < bmf3x3_pkg::N_RES; i++) begin
      if (res_v[i]) begin
        fifo_r[wr_idx[i]] <= res[i];
      end
    end
  end

  // Queue pointers and fill level.
  assign out_acc = out_valid & out_ready;
  assign cnt_nxt = cnt_r + bmf3x3_pkg::FIFO_CW'(res_n) - bmf3x3_pkg::FIFO_CW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + bmf3x3_pkg::FIFO_AW'(res_n);
      rptr_r <= rptr_r + bmf3x3_pkg::FIFO_AW'(out_acc);
      cnt_r  <= cnt_nxt;
    end
  end

  // Take a pixel only when the queue holds room for its results after those in flight.
  assign pend     = cnt_r + bmf3x3_pkg::FIFO_CW'(res_n);
  assign in_ready = (pend <= bmf3x3_pkg::FIFO_CW'(bmf3x3_pkg::FIFO_DEPTH - bmf3x3_pkg::N_RES));

  // Output channel from the queue head.
  assign out_valid      = (cnt_r != '0);
  assign out_row        = fifo_r[rptr_r].row;
  assign out_col        = fifo_r[rptr_r].col;
  assign out_pixel_out  = fifo_r[rptr_r].pix;
  assign out_frame_done = fifo_r[rptr_r].done;

  // The queue never takes more results than it can hold.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (pend <= bmf3x3_pkg::FIFO_CW'(bmf3x3_pkg::FIFO_DEPTH)))
    else $error("result queue overflow");

  // The frame end marker only travels with the bottom right pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_row == hlast_r && out_col == wlast_r))
    else $error("frame end marker on wrong pixel");

  // The pixel in the filter stage always lies inside the configured image.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_col_r <= wlast_r && s1_row_r <= hlast_r))
    else $error("filter stage position outside image");

  // The last pixel of a frame returns the position counters to the origin.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_wr && c_cur == wlast_r && r_cur == hlast_r)
    |=> (row_count_r == '0 && col_count_r == '0))
    else $error("counters did not wrap at frame end");

endmodule

@@ hdl/bmf3x3_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the filter's line buffers.
module bmf3x3_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
